[sv/tgr_pkg.sv]
package tgr_pkg;

	// configuration port
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 16;
	localparam int TICKS_BITS     = 16;
	localparam int THRESH_BITS    = 12;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_SINGLE_TAP_TICKS = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_LONG_TAP_TICKS   = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DRAG_THRESH_X    = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DRAG_THRESH_Y    = 2'd3;

	localparam logic [TICKS_BITS-1:0]  SINGLE_TAP_TICKS_RST = 16'd200;
	localparam logic [TICKS_BITS-1:0]  LONG_TAP_TICKS_RST   = 16'd1000;
	localparam logic [THRESH_BITS-1:0] DRAG_THRESH_RST      = 12'd25;

	// event kinds
	localparam int FUNC_BITS = 2;
	localparam logic [FUNC_BITS-1:0] FUNC_PRESS   = 2'd0;
	localparam logic [FUNC_BITS-1:0] FUNC_MOVE    = 2'd1;
	localparam logic [FUNC_BITS-1:0] FUNC_RELEASE = 2'd2;
	localparam logic [FUNC_BITS-1:0] FUNC_TICK    = 2'd3;

	// gesture codes
	localparam int GEST_BITS = 2;
	localparam logic [GEST_BITS-1:0] GEST_SINGLE = 2'd0;
	localparam logic [GEST_BITS-1:0] GEST_DOUBLE = 2'd1;
	localparam logic [GEST_BITS-1:0] GEST_LONG   = 2'd2;
	localparam logic [GEST_BITS-1:0] GEST_DRAG   = 2'd3;

	// one-shot timer control for one item
	typedef struct packed {
		logic start;
		logic stop;
		logic tick;
	} tmr_ctrl_t;

endpackage

[sv/tgr_timer.sv]
module tgr_timer #(
	parameter int TIMER_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tgr_pkg::tmr_ctrl_t    ctrl,
	input  logic [TIMER_BITS-1:0] limit,
	output logic                  fire
);
	import tgr_pkg::*;

	logic [TIMER_BITS-1:0] count_q;
	logic                  running_q;
	logic [TIMER_BITS-1:0] count_nxt;

	// saturating increment
	assign count_nxt = (count_q == {TIMER_BITS{1'b1}}) ? count_q : count_q + 1'b1;
	assign fire      = ctrl.tick && running_q && (count_nxt >= limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			running_q <= 1'b0;
		end else if (ctrl.start) begin
			count_q   <= '0;
			running_q <= 1'b1;
		end else if (ctrl.stop) begin
			running_q <= 1'b0;
		end else if (ctrl.tick && running_q) begin
			count_q <= count_nxt;
			if (fire) begin
				running_q <= 1'b0;
			end
		end
	end

	a_fire_needs_running: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> !running_q || $past(ctrl.start))
		else $error("timer fired but kept running");

endmodule

[sv/tgr_fsm.sv]
module tgr_fsm #(
	parameter int COORD_BITS = 12,
	parameter int TIMER_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step,
	input  logic [tgr_pkg::FUNC_BITS-1:0]      func,
	input  logic [COORD_BITS-1:0]              pos_x,
	input  logic [COORD_BITS-1:0]              pos_y,
	input  logic [tgr_pkg::THRESH_BITS-1:0]    thresh_x,
	input  logic [tgr_pkg::THRESH_BITS-1:0]    thresh_y,
	input  logic [TIMER_BITS-1:0]              long_limit,
	input  logic [TIMER_BITS-1:0]              tap_limit,
	output logic                               emit,
	output logic [tgr_pkg::GEST_BITS-1:0]      gesture,
	output logic signed [COORD_BITS:0]         move_x,
	output logic signed [COORD_BITS:0]         move_y
);
	import tgr_pkg::*;

	localparam int CMP_BITS = (COORD_BITS + 1 > THRESH_BITS) ? COORD_BITS + 1 : THRESH_BITS;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_INITIAL = 3'd1;
	localparam logic [2:0] ST_PENDING = 3'd2;
	localparam logic [2:0] ST_LONG    = 3'd3;
	localparam logic [2:0] ST_SECOND  = 3'd4;
	localparam logic [2:0] ST_MOVING  = 3'd5;

	logic [2:0]            state_q, state_nxt;
	logic [COORD_BITS-1:0] last_x_q, last_y_q;
	logic                  load_pos;
	logic [COORD_BITS:0]   dx, dy, adx, ady;
	logic                  over;
	tmr_ctrl_t             long_ctrl, tap_ctrl;
	logic                  long_fire, tap_fire;

	assign dx  = {1'b0, pos_x} - {1'b0, last_x_q};
	assign dy  = {1'b0, pos_y} - {1'b0, last_y_q};
	assign adx = dx[COORD_BITS] ? -dx : dx;
	assign ady = dy[COORD_BITS] ? -dy : dy;
	assign over = (CMP_BITS'(adx) > CMP_BITS'(thresh_x)) ||
		(CMP_BITS'(ady) > CMP_BITS'(thresh_y));

	always_comb begin
		state_nxt = state_q;
		load_pos  = 1'b0;
		emit      = 1'b0;
		gesture   = GEST_SINGLE;
		move_x    = '0;
		move_y    = '0;
		long_ctrl = '0;
		tap_ctrl  = '0;
		if (step) begin
			case (func)
				FUNC_PRESS: begin
					load_pos = 1'b1;
					if (state_q == ST_IDLE) begin
						long_ctrl.start = 1'b1;
						state_nxt       = ST_INITIAL;
					end else if (state_q == ST_PENDING) begin
						tap_ctrl.stop   = 1'b1;
						long_ctrl.start = 1'b1;
						state_nxt       = ST_SECOND;
					end
				end
				FUNC_MOVE: begin
					if ((state_q inside {ST_INITIAL, ST_SECOND, ST_LONG}) && over) begin
						state_nxt = ST_MOVING;
						emit      = 1'b1;
					end else if (state_q == ST_MOVING) begin
						emit = 1'b1;
					end
					if (emit) begin
						load_pos = 1'b1;
						gesture  = GEST_DRAG;
						move_x   = dx;
						move_y   = dy;
					end
				end
				FUNC_RELEASE: begin
					case (state_q)
						ST_INITIAL: begin
							long_ctrl.stop = 1'b1;
							tap_ctrl.start = 1'b1;
							state_nxt      = ST_PENDING;
						end
						ST_SECOND: begin
							long_ctrl.stop = 1'b1;
							state_nxt      = ST_IDLE;
							emit           = 1'b1;
							gesture        = GEST_DOUBLE;
						end
						ST_LONG: begin
							state_nxt = ST_IDLE;
							emit      = 1'b1;
							gesture   = GEST_LONG;
						end
						ST_MOVING: begin
							state_nxt = ST_IDLE;
						end
						default: begin
						end
					endcase
				end
				default: begin
					// tick: long timer first, then tap timer
					long_ctrl.tick = 1'b1;
					tap_ctrl.tick  = 1'b1;
					if (long_fire && (state_q inside {ST_INITIAL, ST_SECOND})) begin
						state_nxt = ST_LONG;
					end
					if (tap_fire && state_q == ST_PENDING) begin
						state_nxt = ST_IDLE;
						emit      = 1'b1;
						gesture   = GEST_SINGLE;
					end
				end
			endcase
		end
	end

	tgr_timer #(.TIMER_BITS(TIMER_BITS)) u_long_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (long_ctrl),
		.limit  (long_limit),
		.fire   (long_fire)
	);

	tgr_timer #(.TIMER_BITS(TIMER_BITS)) u_tap_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (tap_ctrl),
		.limit  (tap_limit),
		.fire   (tap_fire)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			last_x_q <= '0;
			last_y_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (load_pos) begin
				last_x_q <= pos_x;
				last_y_q <= pos_y;
			end
		end
	end

	a_non_drag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		emit && gesture != GEST_DRAG |-> move_x == '0 && move_y == '0)
		else $error("non-drag gesture with nonzero displacement");

	a_drag_lands_moving: assert property (@(posedge clk) disable iff (!arst_n)
		emit && gesture == GEST_DRAG |=> state_q == ST_MOVING)
		else $error("drag reported outside moving state");

endmodule

[sv/touch_gesture_recognizer.sv]
// channel   direction  handshake           word
// in        input      in_valid/in_stall   func, pos_x, pos_y
// out       output     out_valid/out_stall gesture, move_x, move_y
// cfg       input      cfg_wen             cfg_index, cfg_data
//
// one word per cycle sustained while the output is not stalled; a word is registered in the
// input stage and its result is then registered in the output register
// the gesture state, last position and both timers update in the single cycle
// that a word leaves the input stage, so back-to-back words see each other's state
// arst_n clears state to idle, timers stopped, position zero, registers to defaults
// out_stall holds the output word; the input stage then stalls only if it is full
module touch_gesture_recognizer #(
	parameter int COORD_BITS = 12,
	parameter int TIMER_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input word channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [tgr_pkg::FUNC_BITS-1:0]       func,
	input  logic [COORD_BITS-1:0]               pos_x,
	input  logic [COORD_BITS-1:0]               pos_y,
	// result word channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [tgr_pkg::GEST_BITS-1:0]       gesture,
	output logic signed [COORD_BITS:0]          move_x,
	output logic signed [COORD_BITS:0]          move_y,
	// register writes
	input  logic                                cfg_wen,
	input  logic [tgr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [tgr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import tgr_pkg::*;

	// configuration registers
	logic [TICKS_BITS-1:0]  single_tap_ticks_q;
	logic [TICKS_BITS-1:0]  long_tap_ticks_q;
	logic [THRESH_BITS-1:0] drag_thresh_x_q;
	logic [THRESH_BITS-1:0] drag_thresh_y_q;

	// input stage
	logic                  valid_s1;
	logic [FUNC_BITS-1:0]  func_s1;
	logic [COORD_BITS-1:0] pos_x_s1;
	logic [COORD_BITS-1:0] pos_y_s1;

	// output register
	logic                        out_valid_q;
	logic [GEST_BITS-1:0]        gesture_q;
	logic signed [COORD_BITS:0]  move_x_q;
	logic signed [COORD_BITS:0]  move_y_q;

	logic                        step;
	logic                        res_emit;
	logic [GEST_BITS-1:0]        res_gesture;
	logic signed [COORD_BITS:0]  res_move_x;
	logic signed [COORD_BITS:0]  res_move_y;
	logic [TIMER_BITS-1:0]       long_limit;
	logic [TIMER_BITS-1:0]       tap_limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			single_tap_ticks_q <= SINGLE_TAP_TICKS_RST;
			long_tap_ticks_q   <= LONG_TAP_TICKS_RST;
			drag_thresh_x_q    <= DRAG_THRESH_RST;
			drag_thresh_y_q    <= DRAG_THRESH_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_SINGLE_TAP_TICKS: single_tap_ticks_q <= cfg_data[TICKS_BITS-1:0];
				CFG_LONG_TAP_TICKS:   long_tap_ticks_q   <= cfg_data[TICKS_BITS-1:0];
				CFG_DRAG_THRESH_X:    drag_thresh_x_q    <= cfg_data[THRESH_BITS-1:0];
				CFG_DRAG_THRESH_Y:    drag_thresh_y_q    <= cfg_data[THRESH_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// tick limits clamp to the largest count a narrow timer can hold
	generate
		if (TIMER_BITS >= TICKS_BITS) begin : g_wide_timer
			assign long_limit = TIMER_BITS'(long_tap_ticks_q);
			assign tap_limit  = TIMER_BITS'(single_tap_ticks_q);
		end else begin : g_narrow_timer
			assign long_limit = (|long_tap_ticks_q[TICKS_BITS-1:TIMER_BITS]) ?
				{TIMER_BITS{1'b1}} : long_tap_ticks_q[TIMER_BITS-1:0];
			assign tap_limit  = (|single_tap_ticks_q[TICKS_BITS-1:TIMER_BITS]) ?
				{TIMER_BITS{1'b1}} : single_tap_ticks_q[TIMER_BITS-1:0];
		end
	endgenerate

	// the staged word moves on whenever the output register is free or draining
	assign step     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			func_s1  <= func;
			pos_x_s1 <= pos_x;
			pos_y_s1 <= pos_y;
		end
	end

	tgr_fsm #(
		.COORD_BITS (COORD_BITS),
		.TIMER_BITS (TIMER_BITS)
	) u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.func       (func_s1),
		.pos_x      (pos_x_s1),
		.pos_y      (pos_y_s1),
		.thresh_x   (drag_thresh_x_q),
		.thresh_y   (drag_thresh_y_q),
		.long_limit (long_limit),
		.tap_limit  (tap_limit),
		.emit       (res_emit),
		.gesture    (res_gesture),
		.move_x     (res_move_x),
		.move_y     (res_move_y)
	);

	// result register, loaded only when a word produces a gesture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= res_emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_emit) begin
			gesture_q <= res_gesture;
			move_x_q  <= res_move_x;
			move_y_q  <= res_move_y;
		end
	end

	assign out_valid = out_valid_q;
	assign gesture   = gesture_q;
	assign move_x    = move_x_q;
	assign move_y    = move_y_q;

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with no word held");

	a_result_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(step))
		else $error("result word appeared without a processed input word");

endmodule

[tb/tb_touch_gesture_recognizer.sv]
module tb_touch_gesture_recognizer;
	timeunit 1ns;
	timeprecision 1ps;

	import tgr_pkg::*;

	localparam int COORD_W       = 12;
	localparam int TIMER_W       = 16;
	localparam int HOLD_CYCLES   = 4;       // input stage and output register of the block, plus margin
	localparam int CYCLE_LIMIT   = 300000;
	localparam int RANDOM_WORDS  = 650;
	localparam int SHORT_CFG_ROW = 14;      // directed rows from here run on short timers

	// gesture machine states, in the order the block encodes them
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INITIAL,
		ST_PENDING,
		ST_LONG,
		ST_SECOND,
		ST_MOVING
	} touch_state_e;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PATTERN
	} stall_mode_e;

	typedef struct packed {
		logic [GEST_BITS-1:0]    gesture;
		logic signed [COORD_W:0] move_x;
		logic signed [COORD_W:0] move_y;
	} gesture_word_t;

	// one directed word; typed rows carry their own expected outcome
	typedef struct packed {
		logic                  typed;
		logic [FUNC_BITS-1:0]  func;
		logic [COORD_W-1:0]    x;
		logic [COORD_W-1:0]    y;
		logic                  has_gesture;
		gesture_word_t         word;
	} event_row_t;

	typedef struct packed {
		logic [TICKS_BITS-1:0]  tap_limit;
		logic [TICKS_BITS-1:0]  long_limit;
		logic [THRESH_BITS-1:0] thr_x;
		logic [THRESH_BITS-1:0] thr_y;
	} touch_cfg_t;

	typedef struct packed {
		touch_state_e       st;
		logic [COORD_W-1:0] last_x;
		logic [COORD_W-1:0] last_y;
		logic [TIMER_W-1:0] long_cnt;
		logic               long_run;
		logic [TIMER_W-1:0] tap_cnt;
		logic               tap_run;
	} touch_ctx_t;

	localparam gesture_word_t NO_GESTURE = '{GEST_SINGLE, 13'sd0, 13'sd0};

	// first part at reset settings, then at tap 1, long 2, thresholds 0 and 4095
	localparam event_row_t DIRECTED_WORDS [25] = '{
		// idle ignores everything but a press
		'{1'b1, FUNC_TICK,    12'd0,    12'd0,    1'b0, NO_GESTURE},
		'{1'b1, FUNC_RELEASE, 12'd4095, 12'd4095, 1'b0, NO_GESTURE},
		'{1'b1, FUNC_MOVE,    12'd4095, 12'd4095, 1'b0, NO_GESTURE},
		// a move equal to the threshold is not a drag, one more is
		'{1'b1, FUNC_PRESS,   12'd0,    12'd0,    1'b0, NO_GESTURE},
		'{1'b1, FUNC_MOVE,    12'd25,   12'd25,   1'b0, NO_GESTURE},
		'{1'b1, FUNC_MOVE,    12'd26,   12'd0,    1'b1, '{GEST_DRAG, 13'sd26, 13'sd0}},
		'{1'b1, FUNC_MOVE,    12'd0,    12'd4095, 1'b1, '{GEST_DRAG, -13'sd26, 13'sd4095}},
		// a press while moving still records the position
		'{1'b1, FUNC_PRESS,   12'd4095, 12'd0,    1'b0, NO_GESTURE},
		'{1'b1, FUNC_MOVE,    12'd0,    12'd4095, 1'b1, '{GEST_DRAG, -13'sd4095, 13'sd4095}},
		'{1'b1, FUNC_RELEASE, 12'd0,    12'd0,    1'b0, NO_GESTURE},
		// double tap
		'{1'b0, FUNC_PRESS,   12'd100,  12'd100,  1'b0, NO_GESTURE},
		'{1'b0, FUNC_RELEASE, 12'd100,  12'd100,  1'b0, NO_GESTURE},
		'{1'b0, FUNC_PRESS,   12'd100,  12'd100,  1'b0, NO_GESTURE},
		'{1'b1, FUNC_RELEASE, 12'd0,    12'd0,    1'b1, '{GEST_DOUBLE, 13'sd0, 13'sd0}},
		// long touch, with moves that stay within zero and full-scale thresholds
		'{1'b1, FUNC_PRESS,   12'd4095, 12'd4095, 1'b0, NO_GESTURE},
		'{1'b1, FUNC_MOVE,    12'd4095, 12'd4095, 1'b0, NO_GESTURE},
		'{1'b0, FUNC_TICK,    12'd0,    12'd0,    1'b0, NO_GESTURE},
		'{1'b0, FUNC_TICK,    12'd0,    12'd0,    1'b0, NO_GESTURE},
		'{1'b1, FUNC_MOVE,    12'd4095, 12'd0,    1'b0, NO_GESTURE},
		'{1'b1, FUNC_RELEASE, 12'd4095, 12'd0,    1'b1, '{GEST_LONG, 13'sd0, 13'sd0}},
		// single tap on the first tick after release
		'{1'b0, FUNC_PRESS,   12'd7,    12'd9,    1'b0, NO_GESTURE},
		'{1'b0, FUNC_RELEASE, 12'd7,    12'd9,    1'b0, NO_GESTURE},
		'{1'b0, FUNC_TICK,    12'd0,    12'd0,    1'b0, NO_GESTURE},
		// a one-step move beats a zero threshold
		'{1'b0, FUNC_PRESS,   12'd0,    12'd0,    1'b0, NO_GESTURE},
		'{1'b1, FUNC_MOVE,    12'd1,    12'd4095, 1'b1, '{GEST_DRAG, 13'sd1, 13'sd4095}}
	};

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_stall;
	logic [FUNC_BITS-1:0]          func      = FUNC_TICK;
	logic [COORD_W-1:0]            pos_x     = '0;
	logic [COORD_W-1:0]            pos_y     = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [GEST_BITS-1:0]          gesture;
	logic signed [COORD_W:0]       move_x;
	logic signed [COORD_W:0]       move_y;
	logic                          cfg_wen   = 1'b0;
	logic [CFG_INDEX_BITS-1:0]     cfg_index = CFG_SINGLE_TAP_TICKS;
	logic [CFG_DATA_BITS-1:0]      cfg_data  = '0;

	// predictor copy of the block
	touch_ctx_t    touch;
	touch_cfg_t    cfg_model;
	gesture_word_t gestures_due [$];

	int mismatches         = 0;
	int live_words         = 0;
	int burst_left         = 0;
	int cycle_count        = 0;

	stall_mode_e   stall_mode = STALL_NONE;
	logic [15:0]   stall_bits = '0;
	logic [7:0]    stall_tick = '0;

	touch_gesture_recognizer #(
		.COORD_BITS(COORD_W),
		.TIMER_BITS(TIMER_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.gesture  (gesture),
		.move_x   (move_x),
		.move_y   (move_y),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit, generous against the slowest legal run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side stalls: none, random one time in three, or a repeating 16-bit pattern
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1'b1;
		if (stall_tick[5:0] == '0) begin
			stall_mode <= stall_mode_e'($urandom_range(0, 2));
			stall_bits <= 16'($urandom);
		end
		case (stall_mode)
			STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
			STALL_PATTERN: out_stall <= stall_bits[stall_tick[3:0]];
			default: out_stall <= 1'b0;
		endcase
	end

	// every accepted result word against the oldest prediction
	always @(posedge clk) begin : check_gestures
		gesture_word_t want;
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			if (gestures_due.size() == 0) begin
				$error("unexpected result word: gesture %0d move_x %0d move_y %0d",
					gesture, move_x, move_y);
				mismatches++;
			end else begin
				want = gestures_due.pop_front();
				if (gesture !== want.gesture) begin
					$error("gesture: expected %0d, got %0d", want.gesture, gesture);
					mismatches++;
				end
				if (move_x !== want.move_x) begin
					$error("move_x: expected %0d, got %0d", want.move_x, move_x);
					mismatches++;
				end
				if (move_y !== want.move_y) begin
					$error("move_y: expected %0d, got %0d", want.move_y, move_y);
					mismatches++;
				end
			end
		end
	end

	function automatic int magnitude(input int v);
		return (v < 0) ? -v : v;
	endfunction

	// one tick of a one-shot timer; true when it fires
	function automatic logic advance_timer(inout logic [TIMER_W-1:0] cnt, inout logic run,
			input logic [TICKS_BITS-1:0] lim);
		if (!run)
			return 1'b0;
		if (cnt != '1)
			cnt = cnt + 1'b1;
		if (cnt >= lim) begin
			run = 1'b0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// gesture machine: next state and the result word, if any, for one event
	task automatic recognize(input logic [FUNC_BITS-1:0] f, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, output logic has, output gesture_word_t w);
		int   dx;
		int   dy;
		logic long_fired;
		logic tap_fired;
		has = 1'b0;
		w   = NO_GESTURE;
		dx  = int'(x) - int'(touch.last_x);
		dy  = int'(y) - int'(touch.last_y);
		case (f)
			FUNC_PRESS: begin
				touch.last_x = x;
				touch.last_y = y;
				if (touch.st == ST_IDLE) begin
					touch.long_cnt = '0;
					touch.long_run = 1'b1;
					touch.st       = ST_INITIAL;
				end else if (touch.st == ST_PENDING) begin
					touch.tap_run  = 1'b0;
					touch.long_cnt = '0;
					touch.long_run = 1'b1;
					touch.st       = ST_SECOND;
				end
			end
			FUNC_MOVE: begin
				if (touch.st == ST_MOVING) begin
					has = 1'b1;
				end else if (touch.st == ST_INITIAL || touch.st == ST_SECOND ||
						touch.st == ST_LONG) begin
					if (magnitude(dx) > int'(cfg_model.thr_x) ||
							magnitude(dy) > int'(cfg_model.thr_y)) begin
						touch.st = ST_MOVING;
						has      = 1'b1;
					end
				end
				if (has) begin
					touch.last_x = x;
					touch.last_y = y;
					w = '{GEST_DRAG, dx[COORD_W:0], dy[COORD_W:0]};
				end
			end
			FUNC_RELEASE: begin
				case (touch.st)
					ST_INITIAL: begin
						touch.long_run = 1'b0;
						touch.tap_cnt  = '0;
						touch.tap_run  = 1'b1;
						touch.st       = ST_PENDING;
					end
					ST_SECOND: begin
						touch.long_run = 1'b0;
						touch.st       = ST_IDLE;
						has            = 1'b1;
						w.gesture      = GEST_DOUBLE;
					end
					ST_LONG: begin
						touch.st  = ST_IDLE;
						has       = 1'b1;
						w.gesture = GEST_LONG;
					end
					ST_MOVING: touch.st = ST_IDLE;
					default: ;
				endcase
			end
			default: begin
				// long timer goes first; only the tap timer reports
				long_fired = advance_timer(touch.long_cnt, touch.long_run, cfg_model.long_limit);
				if (long_fired && (touch.st == ST_INITIAL || touch.st == ST_SECOND))
					touch.st = ST_LONG;
				tap_fired = advance_timer(touch.tap_cnt, touch.tap_run, cfg_model.tap_limit);
				if (tap_fired && touch.st == ST_PENDING) begin
					touch.st  = ST_IDLE;
					has       = 1'b1;
					w.gesture = GEST_SINGLE;
				end
			end
		endcase
	endtask

	// drive one word, hold it until taken, then predict from the edge that took it
	task automatic send_word(input event_row_t row);
		logic          has;
		gesture_word_t w;
		in_valid <= 1'b1;
		func     <= row.func;
		pos_x    <= row.x;
		pos_y    <= row.y;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		recognize(row.func, row.x, row.y, has, w);
		if (row.typed) begin
			has = row.has_gesture;
			w   = row.word;
		end
		if (has)
			gestures_due.push_back(w);
		live_words++;
	endtask

	// sender bursts with random gaps between them
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 15);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic offer(input logic [FUNC_BITS-1:0] f, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y);
		pace();
		send_word('{1'b0, f, x, y, 1'b0, NO_GESTURE});
	endtask

	// hold the sender until every predicted word is out and the pipe is quiet
	task automatic drain();
		in_valid <= 1'b0;
		while (gestures_due.size() != 0)
			@(posedge clk);
		repeat (HOLD_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			CFG_SINGLE_TAP_TICKS: cfg_model.tap_limit  = data;
			CFG_LONG_TAP_TICKS:   cfg_model.long_limit = data;
			CFG_DRAG_THRESH_X:    cfg_model.thr_x      = data[THRESH_BITS-1:0];
			default:              cfg_model.thr_y      = data[THRESH_BITS-1:0];
		endcase
	endtask

	task automatic set_config(input logic [TICKS_BITS-1:0] tap, input logic [TICKS_BITS-1:0] lng,
			input logic [THRESH_BITS-1:0] tx, input logic [THRESH_BITS-1:0] ty);
		drain();
		write_reg(CFG_SINGLE_TAP_TICKS, tap);
		write_reg(CFG_LONG_TAP_TICKS, lng);
		write_reg(CFG_DRAG_THRESH_X, CFG_DATA_BITS'(tx));
		write_reg(CFG_DRAG_THRESH_Y, CFG_DATA_BITS'(ty));
		cfg_wen <= 1'b0;
	endtask

	// coordinates lean on the edges of the range now and then
	function automatic logic [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return COORD_W'($urandom_range(0, 4095));
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] base,
			input int span);
		int v;
		v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return COORD_W'(v);
	endfunction

	// tick counts that land around a timer limit, short when the limit is huge
	function automatic int ticks_near(input logic [TICKS_BITS-1:0] lim);
		if (lim > 48)
			return $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, int'(lim));
		return int'(lim) + $urandom_range(0, 2);
	endfunction

	function automatic int ticks_short_of(input logic [TICKS_BITS-1:0] lim);
		if (lim > 48)
			return $urandom_range(0, 6);
		return $urandom_range(0, int'(lim) - 1);
	endfunction

	task automatic tick_run(input int n);
		repeat (n) offer(FUNC_TICK, rand_coord(), rand_coord());
	endtask

	// one random gesture: mostly well formed, some noise and broken sequences
	task automatic play_script();
		int                   pick;
		int                   n;
		logic [FUNC_BITS-1:0] f;
		logic [COORD_W-1:0]   bx;
		logic [COORD_W-1:0]   by;
		pick = $urandom_range(0, 99);
		bx   = rand_coord();
		by   = rand_coord();
		if (pick < 20) begin
			// single tap
			offer(FUNC_PRESS, bx, by);
			tick_run($urandom_range(0, 3));
			offer(FUNC_RELEASE, rand_coord(), rand_coord());
			tick_run(ticks_near(cfg_model.tap_limit));
		end else if (pick < 35) begin
			// double tap, second press inside the tap wait
			offer(FUNC_PRESS, bx, by);
			tick_run($urandom_range(0, 2));
			offer(FUNC_RELEASE, rand_coord(), rand_coord());
			tick_run(ticks_short_of(cfg_model.tap_limit));
			offer(FUNC_PRESS, near_coord(bx, 3), near_coord(by, 3));
			tick_run($urandom_range(0, 2));
			offer(FUNC_RELEASE, rand_coord(), rand_coord());
		end else if (pick < 50) begin
			// long touch, maybe with a move inside the thresholds
			offer(FUNC_PRESS, bx, by);
			tick_run(ticks_near(cfg_model.long_limit));
			if ($urandom_range(0, 1) == 0)
				offer(FUNC_MOVE, near_coord(bx, int'(cfg_model.thr_x)),
					near_coord(by, int'(cfg_model.thr_y)));
			offer(FUNC_RELEASE, rand_coord(), rand_coord());
			tick_run($urandom_range(0, 3));
		end else if (pick < 75) begin
			// drag: moves straddle the thresholds, ticks can fire the long timer
			offer(FUNC_PRESS, bx, by);
			n = $urandom_range(1, 6);
			repeat (n) begin
				offer(FUNC_MOVE,
					near_coord(touch.last_x, int'(cfg_model.thr_x) + $urandom_range(0, 40)),
					near_coord(touch.last_y, int'(cfg_model.thr_y) + $urandom_range(0, 40)));
				if ($urandom_range(0, 2) == 0)
					tick_run(ticks_near(cfg_model.long_limit));
			end
			offer(FUNC_RELEASE, rand_coord(), rand_coord());
			tick_run($urandom_range(0, 3));
		end else if (pick < 87) begin
			// noise
			n = $urandom_range(1, 8);
			repeat (n) begin
				f = FUNC_BITS'($urandom_range(0, 3));
				offer(f, rand_coord(), rand_coord());
			end
		end else begin
			case ($urandom_range(0, 2))
				0: begin
					// release and move with nothing pressed
					offer(FUNC_RELEASE, bx, by);
					offer(FUNC_MOVE, rand_coord(), rand_coord());
				end
				1: begin
					// second press while still held
					offer(FUNC_PRESS, bx, by);
					offer(FUNC_PRESS, rand_coord(), rand_coord());
					tick_run(ticks_near(cfg_model.long_limit));
				end
				default: begin
					// extra release and a move during the tap wait
					offer(FUNC_PRESS, bx, by);
					offer(FUNC_RELEASE, bx, by);
					offer(FUNC_RELEASE, rand_coord(), rand_coord());
					offer(FUNC_MOVE, rand_coord(), rand_coord());
				end
			endcase
		end
	endtask

	initial begin : stimulus
		int phase;
		int phase_goal;
		touch     = '0;
		touch.st  = ST_IDLE;
		cfg_model = '{SINGLE_TAP_TICKS_RST, LONG_TAP_TICKS_RST, DRAG_THRESH_RST,
			DRAG_THRESH_RST};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words, reset settings first
		for (int i = 0; i < $size(DIRECTED_WORDS); i++) begin
			if (i == SHORT_CFG_ROW)
				set_config(16'd1, 16'd2, 12'd0, 12'd4095);
			else
				pace();
			send_word(DIRECTED_WORDS[i]);
		end

		// random gestures over several settings, extremes among them
		live_words = 0;
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: set_config(16'd1, 16'd1, 12'd0, 12'd0);
				1: set_config(16'd3, 16'd8, 12'd25, 12'd25);
				2: set_config(16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF);
				3: set_config(16'($urandom_range(1, 16)), 16'($urandom_range(1, 40)),
					12'($urandom_range(0, 300)), 12'($urandom_range(0, 300)));
				default: set_config(16'd2, 16'd4, 12'hFFF, 12'd0);
			endcase
			phase_goal = (phase + 1) * RANDOM_WORDS / 5;
			while (live_words < phase_goal) begin
				play_script();
				// now and then let every result drain before going on
				if ($urandom_range(0, 59) == 0)
					drain();
			end
		end

		drain();
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
